@@ sv/mpfs_pkg.sv @@
// ----------------------------------------------------------------------------
// mpfs_pkg
// Shared widths, codes and types of the multilevel priority ready queue.
// ----------------------------------------------------------------------------
package mpfs_pkg;

  // Field widths of the request and the response.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned TASK_W   = 6;
  localparam int unsigned PRIO_W   = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_W    = 4;
  // Wide enough to hold any level count up to the largest number of levels.
  localparam int unsigned LVL_W    = 6;

  // Defaults of the top-level parameters.
  localparam int unsigned NUM_PRIORITIES_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF    = 16;
  localparam int unsigned TASK_ID_BITS_DEF   = 6;

  // Reset value of the levels-in-use register.
  localparam logic [CFG_W-1:0] LEVELS_RST = 4'd8;

  // Operation codes. The last one does nothing and returns all zeros.
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SCHED  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADPRIO  = 3'd4;

  // Per-lane control handed to every cell of one lane.
  typedef struct packed {
    logic add;   // append at the tail
    logic pop;   // whole lane moves one place towards the head
    logic walk;  // remove search in progress on this lane
  } cell_ctl_t;

endpackage

@@ sv/mpfs_req_if.sv @@
// ----------------------------------------------------------------------------
// mpfs_req_if
// Request channel: valid, ready and one queue operation.
// ----------------------------------------------------------------------------
interface mpfs_req_if
  import mpfs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [TASK_W-1:0]   task_id;
  logic [PRIO_W-1:0]   priority_req;

  modport source (output valid, output opcode, output task_id, output priority_req,
                  input ready);
  modport sink   (input valid, input opcode, input task_id, input priority_req,
                  output ready);
endinterface

@@ sv/mpfs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mpfs_rsp_if
// Response channel: valid, ready and the outcome of one request.
// ----------------------------------------------------------------------------
interface mpfs_rsp_if
  import mpfs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [TASK_W-1:0]   chosen_task;
  logic [PRIO_W-1:0]   chosen_priority;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output chosen_task, output chosen_priority,
                  output status, input ready);
  modport sink   (input valid, input chosen_task, input chosen_priority,
                  input status, output ready);
endinterface

@@ sv/mpfs_cell.sv @@
// ----------------------------------------------------------------------------
// mpfs_cell
// One queue position of one priority lane. Position zero is the head.
// ----------------------------------------------------------------------------
module mpfs_cell
  import mpfs_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 6,
  parameter int unsigned CW  = 5,
  parameter int unsigned PW  = 4
) (
  input  logic          clk_i,
  input  cell_ctl_t     ctl_i,
  input  logic [PW-1:0] pos_i,
  input  logic [CW-1:0] cnt_i,
  input  logic [IW-1:0] id_i,
  input  logic [IW-1:0] nxt_i,
  input  logic          seen_i,
  output logic [IW-1:0] val_o,
  output logic          hit_o
);

  logic [IW-1:0] val_q;
  logic          here;
  logic          take_next;

  // The search visits one position per cycle; this cell is looked at when
  // the walk pointer reaches it, and only if it holds a live entry.
  assign here  = ctl_i.walk && (pos_i == PW'(IDX));
  assign hit_o = here && (CW'(IDX) < cnt_i) && (val_q == id_i);

  // Once the match has been seen, each visited cell takes its neighbour's
  // value, so the gap closes as a wave running towards the tail.
  assign take_next = ctl_i.pop || (here && (seen_i || hit_o));

  always_ff @(posedge clk_i) begin
    if (take_next) begin
      val_q <= nxt_i;
    end else if (ctl_i.add && (cnt_i == CW'(IDX))) begin
      val_q <= id_i;
    end
  end

  assign val_o = val_q;

endmodule

@@ sv/multi_priority_fifo_scheduler.sv @@
// ----------------------------------------------------------------------------
// multi_priority_fifo_scheduler
// Ready queue with one FIFO lane per priority level, built as rows of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one operation (add, remove or schedule) under valid/ready;
//   rsp_o returns exactly one response per request, in request order.
//   cfg_we_i/cfg_wdata_i write the number of priority levels in use; write it
//   only while no request is outstanding.
// Request handling:
//   Add, schedule and invalid requests complete in the accepting cycle, and
//   the response is registered and visible in the next cycle: one request per
//   cycle while rsp_o.ready stays high.
//   A remove walks its lane one position per cycle through the cell chain,
//   visiting each of the N entries of the lane (up to QUEUE_DEPTH); the
//   response is registered when the walk ends, and the next request is taken
//   only once the walk ends.
// Reset:
//   All lanes are empty and all eight levels are in use.
// Back-pressure:
//   The response waits in its output register while rsp_o.ready is low; a
//   new request is accepted only once that register is free or being read.
// ----------------------------------------------------------------------------
module multi_priority_fifo_scheduler
  import mpfs_pkg::*;
#(
  parameter int unsigned NUM_PRIORITIES = NUM_PRIORITIES_DEF,
  parameter int unsigned QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int unsigned TASK_ID_BITS   = TASK_ID_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mpfs_req_if.sink         req_i,
  mpfs_rsp_if.source       rsp_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned NP = NUM_PRIORITIES;
  localparam int unsigned QD = QUEUE_DEPTH;
  localparam int unsigned IW = TASK_ID_BITS;
  localparam int unsigned LW = (NP > 1) ? $clog2(NP) : 1;
  localparam int unsigned CW = $clog2(QD + 1);
  localparam int unsigned PW = (QD > 1) ? $clog2(QD) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;

  logic [1:0]          state_q;
  logic [CFG_W-1:0]    levels_q;
  logic [CW-1:0]       cnt_q [NP];
  logic [LW-1:0]       wlvl_q;
  logic [IW-1:0]       wid_q;
  logic [PW-1:0]       pos_q;
  logic                seen_q;
  logic                ov_q;
  logic [TASK_W-1:0]   otask_q;
  logic [PRIO_W-1:0]   oprio_q;
  logic [STATUS_W-1:0] ost_q;

  logic [IW-1:0]       val_w [NP][QD];
  logic [NP*QD-1:0]    hit_w;
  cell_ctl_t           ctl_w [NP];

  logic [LVL_W-1:0]    lv_act;
  logic                acc;
  logic                prio_ok;
  logic [LW-1:0]       rlvl;
  logic [IW-1:0]       in_id;
  logic [IW-1:0]       cell_id;
  logic [NP-1:0]       ne;
  logic                found;
  logic [LW-1:0]       sl;
  logic                hit_any;
  logic                seen_n;
  logic                walk_end;

  // Levels in use, clamped to the number of lanes built.
  assign lv_act = (LVL_W'(levels_q) > LVL_W'(NP)) ? LVL_W'(NP) : LVL_W'(levels_q);

  assign req_i.ready = (state_q == S_IDLE) && (!ov_q || rsp_o.ready);
  assign acc         = req_i.valid && req_i.ready;
  assign prio_ok     = LVL_W'(req_i.priority_req) < lv_act;
  assign rlvl        = LW'(req_i.priority_req);
  assign in_id       = IW'(req_i.task_id);
  assign cell_id     = (state_q == S_WALK) ? wid_q : in_id;

  // Highest non-empty lane among those in use.
  always_comb begin
    found = 1'b0;
    sl    = '0;
    for (int l = 0; l < NP; l++) begin
      ne[l] = (cnt_q[l] != '0) && (LVL_W'(l) < lv_act);
      if (ne[l]) begin
        found = 1'b1;
        sl    = LW'(l);
      end
    end
  end

  // Only the visited cell can report a hit, so a plain OR suffices.
  assign hit_any  = |hit_w;
  assign seen_n   = seen_q || hit_any;
  assign walk_end = (pos_q == PW'(cnt_q[wlvl_q] - CW'(1)));

  // Lane control and the rows of cells.
  for (genvar l = 0; l < NP; l++) begin : g_lane
    always_comb begin
      ctl_w[l].add  = acc && (req_i.opcode == OP_ADD) && prio_ok && (rlvl == LW'(l))
                      && (cnt_q[l] != CW'(QD));
      ctl_w[l].pop  = acc && (req_i.opcode == OP_SCHED) && found && (sl == LW'(l));
      ctl_w[l].walk = (state_q == S_WALK) && (wlvl_q == LW'(l));
    end
    for (genvar k = 0; k < QD; k++) begin : g_cell
      logic [IW-1:0] nxt;
      if (k == QD - 1) begin : g_tail
        assign nxt = '0;
      end else begin : g_mid
        assign nxt = val_w[l][k+1];
      end
      mpfs_cell #(
        .IDX (k),
        .IW  (IW),
        .CW  (CW),
        .PW  (PW)
      ) u_cell (
        .clk_i  (clk_i),
        .ctl_i  (ctl_w[l]),
        .pos_i  (pos_q),
        .cnt_i  (cnt_q[l]),
        .id_i   (cell_id),
        .nxt_i  (nxt),
        .seen_i (seen_q),
        .val_o  (val_w[l][k]),
        .hit_o  (hit_w[l*QD+k])
      );
    end
  end

  // Sequencer, occupancy counters and the response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      levels_q <= LEVELS_RST;
      for (int l = 0; l < NP; l++) cnt_q[l] <= '0;
      wlvl_q   <= '0;
      wid_q    <= '0;
      pos_q    <= '0;
      seen_q   <= 1'b0;
      ov_q     <= 1'b0;
      otask_q  <= '0;
      oprio_q  <= '0;
      ost_q    <= ST_OK;
    end else begin
      if (cfg_we_i) begin
        levels_q <= cfg_wdata_i;
      end
      if (ov_q && rsp_o.ready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            otask_q <= '0;
            oprio_q <= '0;
            ov_q    <= 1'b1;
            case (req_i.opcode)
              OP_ADD: begin
                if (!prio_ok) begin
                  ost_q <= ST_BADPRIO;
                end else if (cnt_q[rlvl] == CW'(QD)) begin
                  ost_q <= ST_FULL;
                end else begin
                  cnt_q[rlvl] <= cnt_q[rlvl] + CW'(1);
                  ost_q       <= ST_OK;
                end
              end
              OP_REMOVE: begin
                if (!prio_ok) begin
                  ost_q <= ST_BADPRIO;
                end else if (cnt_q[rlvl] == '0) begin
                  ost_q <= ST_NOTFOUND;
                end else begin
                  // The response is given when the walk ends.
                  ov_q    <= 1'b0;
                  state_q <= S_WALK;
                  wlvl_q  <= rlvl;
                  wid_q   <= in_id;
                  pos_q   <= '0;
                  seen_q  <= 1'b0;
                end
              end
              OP_SCHED: begin
                if (found) begin
                  otask_q   <= TASK_W'(val_w[sl][0]);
                  oprio_q   <= PRIO_W'(sl);
                  ost_q     <= ST_OK;
                  cnt_q[sl] <= cnt_q[sl] - CW'(1);
                end else begin
                  ost_q <= ST_EMPTY;
                end
              end
              default: begin
                ost_q <= ST_OK;
              end
            endcase
          end
        end
        S_WALK: begin
          if (walk_end) begin
            state_q <= S_IDLE;
            ov_q    <= 1'b1;
            otask_q <= '0;
            oprio_q <= '0;
            if (seen_n) begin
              cnt_q[wlvl_q] <= cnt_q[wlvl_q] - CW'(1);
              ost_q         <= ST_OK;
            end else begin
              ost_q <= ST_NOTFOUND;
            end
          end else begin
            pos_q  <= pos_q + PW'(1);
            seen_q <= seen_n;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid           = ov_q;
  assign rsp_o.chosen_task     = otask_q;
  assign rsp_o.chosen_priority = oprio_q;
  assign rsp_o.status          = ost_q;

endmodule

@@ sv/mpfs_chk.sv @@
// ----------------------------------------------------------------------------
// mpfs_chk
// Port-level checks on the responses of the priority ready queue.
// ----------------------------------------------------------------------------
module mpfs_chk
  import mpfs_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [TASK_W-1:0]   chosen_task_i,
  input logic [PRIO_W-1:0]   chosen_priority_i,
  input logic [STATUS_W-1:0] status_i
);

  // Every response carries one of the defined status codes.
  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (status_i == ST_OK || status_i == ST_EMPTY || status_i == ST_FULL
                     || status_i == ST_NOTFOUND || status_i == ST_BADPRIO))
    else $error("undefined status code");

  // A stalled response holds its contents.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(chosen_task_i)
      && $stable(chosen_priority_i) && $stable(status_i))
    else $error("response changed while stalled");

  // A failed request returns no task.
  a_fail_no_task : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != ST_OK) |-> (chosen_task_i == '0))
    else $error("task returned with a failure status");

  // Nothing ready means no level either.
  a_empty_no_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_EMPTY) |-> (chosen_priority_i == '0))
    else $error("level returned with nothing ready");

endmodule

bind multi_priority_fifo_scheduler mpfs_chk u_mpfs_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .chosen_task_i     (rsp_o.chosen_task),
  .chosen_priority_i (rsp_o.chosen_priority),
  .status_i          (rsp_o.status)
);

@@ dv/multi_priority_fifo_scheduler_tb.sv @@
// ----------------------------------------------------------------------------
// multi_priority_fifo_scheduler_tb
// Self-checking bench for the ready queue: random and directed requests are
// driven under valid/ready with random idling, and each response is compared
// with a queue model kept inside a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_priority_fifo_scheduler_tb;
  import mpfs_pkg::*;

  localparam int unsigned NPRIO = NUM_PRIORITIES_DEF;
  localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic [TASK_W-1:0]   chosen_task;
    logic [PRIO_W-1:0]   chosen_priority;
    logic [STATUS_W-1:0] status;
  } outcome_t;

  // Queue model and store of expected responses.
  class ready_queue_board;
    logic [TASK_W-1:0] lanes [NPRIO][$];
    logic [CFG_W-1:0]  levels_reg;
    outcome_t          pending [$];
    int                mismatches;

    function new();
      levels_reg = LEVELS_RST;
      mismatches = 0;
    endfunction

    // Works out the outcome of one accepted request and updates the queues.
    function void note_request(logic [OP_W-1:0] op, logic [TASK_W-1:0] id,
                               logic [PRIO_W-1:0] prio);
      outcome_t o;
      int lv;
      int k;
      lv = (levels_reg > NPRIO) ? NPRIO : levels_reg;
      o = '0;
      if (op == OP_ADD || op == OP_REMOVE) begin
        if (prio >= lv) begin
          o.status = ST_BADPRIO;
        end else if (op == OP_ADD) begin
          if (lanes[prio].size() >= DEPTH) begin
            o.status = ST_FULL;
          end else begin
            lanes[prio].push_back(id);
            o.status = ST_OK;
          end
        end else begin
          o.status = ST_NOTFOUND;
          for (k = 0; k < lanes[prio].size(); k++) begin
            if (lanes[prio][k] == id) begin
              lanes[prio].delete(k);
              o.status = ST_OK;
              break;
            end
          end
        end
      end else if (op == OP_SCHED) begin
        o.status = ST_EMPTY;
        for (k = lv - 1; k >= 0; k--) begin
          if (lanes[k].size() != 0) begin
            o.chosen_task = lanes[k].pop_front();
            o.chosen_priority = PRIO_W'(k);
            o.status = ST_OK;
            break;
          end
        end
      end
      pending.push_back(o);
    endfunction

    // Compares one response with the oldest expectation.
    function void check_response(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected response task=%0d prio=%0d status=%0d",
                   got.chosen_task, got.chosen_priority, got.status);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected task=%0d prio=%0d status=%0d, got %0d %0d %0d",
                   want.chosen_task, want.chosen_priority, want.status,
                   got.chosen_task, got.chosen_priority, got.status);
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  bit               sink_steady = 1'b0;

  mpfs_req_if req_ch ();
  mpfs_rsp_if rsp_ch ();

  ready_queue_board board = new();

  initial begin
    req_ch.valid = 1'b0;
    req_ch.opcode = '0;
    req_ch.task_id = '0;
    req_ch.priority_req = '0;
    rsp_ch.ready = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  multi_priority_fifo_scheduler i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch.sink),
    .rsp_o       (rsp_ch.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Response side: sample accepted responses and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready)
        board.check_response({rsp_ch.chosen_task, rsp_ch.chosen_priority, rsp_ch.status});
      rsp_ch.ready <= sink_steady ? 1'b1 : ($urandom_range(99) >= 8);
    end
  end

  // Drives one request, with a random idle gap unless the sender is steady.
  // Valid stays high between back-to-back requests; idle gaps and drain()
  // take it low.
  task automatic send_request(logic [OP_W-1:0] op, logic [TASK_W-1:0] id,
                              logic [PRIO_W-1:0] prio, bit steady);
    while (!steady && $urandom_range(99) < 8) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.task_id <= id;
    req_ch.priority_req <= prio;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    board.note_request(op, id, prio);
  endtask

  // Waits until every expected response has come; no remove walk is then running.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic write_levels(logic [CFG_W-1:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.levels_reg = value;
    @(posedge clk_i);
  endtask

  // Random adds, removes, schedules and no-ops; removes often name queued tasks.
  task automatic random_phase(int count, bit steady);
    logic [OP_W-1:0]   op;
    logic [PRIO_W-1:0] prio;
    logic [TASK_W-1:0] id;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      prio = PRIO_W'($urandom_range(7));
      id = TASK_W'($urandom_range(63));
      if (r < 40) op = OP_ADD;
      else if (r < 65) op = OP_REMOVE;
      else if (r < 95) op = OP_SCHED;
      else op = OP_NOP;
      // Removes often pick a task that is really waiting.
      if (op == OP_REMOVE && board.lanes[prio].size() != 0 && $urandom_range(3) != 0)
        id = board.lanes[prio][$urandom_range(board.lanes[prio].size() - 1)];
      send_request(op, id, prio, steady);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty schedule, extremes, full lane, removes, no-op.
    send_request(OP_SCHED, 6'd0, 3'd0, 1'b1);
    send_request(OP_REMOVE, 6'd5, 3'd7, 1'b1);
    send_request(OP_ADD, 6'd63, 3'd7, 1'b1);
    send_request(OP_ADD, 6'd0, 3'd0, 1'b1);
    for (int k = 0; k < DEPTH + 1; k++) send_request(OP_ADD, k[5:0] ^ 6'h2a, 3'd3, 1'b1);
    send_request(OP_REMOVE, 6'h2a ^ 6'd5, 3'd3, 1'b1);
    send_request(OP_REMOVE, 6'd62, 3'd3, 1'b1);
    send_request(OP_NOP, 6'd63, 3'd7, 1'b1);
    send_request(OP_SCHED, 6'd63, 3'd7, 1'b1);

    // Level limits, including zero, the top and above the top.
    write_levels(4'd0);
    send_request(OP_ADD, 6'd1, 3'd0, 1'b0);
    send_request(OP_REMOVE, 6'd0, 3'd0, 1'b0);
    send_request(OP_SCHED, 6'd0, 3'd0, 1'b0);
    write_levels(4'd15);
    random_phase(150, 1'b0);
    write_levels(4'd1);
    random_phase(150, 1'b0);
    write_levels(4'd4);
    sink_steady = 1'b1;
    random_phase(150, 1'b1);
    sink_steady = 1'b0;
    drain();
    write_levels(4'd9);
    random_phase(150, 1'b0);
    write_levels(4'd8);
    random_phase(600, 1'b0);

    drain();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ multi_priority_fifo_scheduler.f @@
sv/mpfs_pkg.sv
sv/mpfs_req_if.sv
sv/mpfs_rsp_if.sv
sv/mpfs_cell.sv
sv/multi_priority_fifo_scheduler.sv
sv/mpfs_chk.sv
dv/multi_priority_fifo_scheduler_tb.sv
